/* src/qdv_pkg.sv */
// Shared types, constants and helpers of the quadrature decoder with velocity read-out.
package qdv_pkg;

  localparam int CntW = 32;
  localparam int ReqDepth = 2;
  localparam logic [23:0] UsPerSec = 24'd1000000;
  localparam logic [23:0] RpcReset = 24'd73204;
  localparam logic [15:0] RadiusReset = 16'd2621;
  localparam logic [31:0] TimeoutReset = 32'd100000;

  typedef enum logic [1:0] {
    ModePin   = 2'd0,
    ModeRead  = 2'd1,
    ModeStart = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CfgRpc     = 2'd0,
    CfgRadius  = 2'd1,
    CfgTimeout = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StepNone,
    StepUp,
    StepDown
  } step_e;

  typedef struct packed {
    logic                      started;
    logic [1:0][CntW-1:0]      total;
    logic [1:0][CntW-1:0]      at_read;
    logic [1:0]                run;
    logic [31:0]               dt;
    logic [31:0]               now;
  } req_t;

  function automatic step_e step_decode(input logic [1:0] prev, input logic [1:0] cur);
    logic [3:0] idx;
    step_e      s;
    idx = {prev, cur};
    case (idx)
      4'b0001, 4'b0111, 4'b1110, 4'b1000: s = StepUp;
      4'b0010, 4'b1011, 4'b1101, 4'b0100: s = StepDown;
      default: s = StepNone;
    endcase
    return s;
  endfunction

  function automatic logic [32:0] clamp_mag(input logic neg, input logic [32:0] mag);
    logic [32:0] lim;
    lim = neg ? 33'h080000000 : 33'h07fffffff;
    return (mag > lim) ? lim : mag;
  endfunction

  function automatic logic [31:0] sat_bits(input logic neg, input logic [32:0] mag);
    logic [32:0] m;
    m = clamp_mag(neg, mag);
    return neg ? 32'(33'd0 - m) : m[31:0];
  endfunction

endpackage

/* src/quadrature_decoder_velocity.sv */
// Top level of the two-wheel x4 quadrature decoder with velocity read-out.
// Pin-change and start requests are accepted every cycle while the read queue has room.
// The back end takes a read only while idle and skips the rate divide for a wheel that is idle or when
// dt is zero, and all arithmetic before start; reads complete one at a time, held until popped.
// Reset is asynchronous, active low: clears the front-end counts and times, config to defaults.
module quadrature_decoder_velocity (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode_i,
  input  logic        wheel_i,
  input  logic [1:0]  left_pins_i,
  input  logic [1:0]  right_pins_i,
  input  logic [31:0] now_us_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] left_count_o,
  output logic [31:0] right_count_o,
  output logic [31:0] left_angle_o,
  output logic [31:0] right_angle_o,
  output logic [31:0] left_rate_o,
  output logic [31:0] right_rate_o,
  output logic [31:0] left_speed_o,
  output logic [31:0] right_speed_o,
  output logic [31:0] sample_time_o,
  output logic        valid_res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import qdv_pkg::*;

  logic [23:0]      rpc_q;
  logic [15:0]      radius_q;
  logic [31:0]      timeout_q;
  logic             req_full, req_push, req_avail, req_pop, out_valid;
  req_t             req_in, req_out;
  logic [1:0][31:0] count, angle, rate, speed;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpc_q     <= RpcReset;
      radius_q  <= RadiusReset;
      timeout_q <= TimeoutReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgRpc:     rpc_q     <= cfg_data_i[23:0];
        CfgRadius:  radius_q  <= cfg_data_i[15:0];
        CfgTimeout: timeout_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  qdv_front u_front (
    .clk_i, .rst_ni,
    .push_i         (push),
    .mode_i, .wheel_i, .left_pins_i, .right_pins_i, .now_us_i,
    .idle_timeout_i (timeout_q),
    .req_full_i     (req_full),
    .req_push_o     (req_push),
    .req_o          (req_in)
  );

  assign full = req_full;

  qdv_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (req_push),
    .data_i  (req_in),
    .full_o  (req_full),
    .pop_i   (req_pop),
    .avail_o (req_avail),
    .data_o  (req_out)
  );

  qdv_back u_back (
    .clk_i, .rst_ni,
    .req_avail_i (req_avail),
    .req_i       (req_out),
    .req_pop_o   (req_pop),
    .rpc_i       (rpc_q),
    .radius_i    (radius_q),
    .out_valid_o (out_valid),
    .out_pop_i   (pop),
    .count_o     (count),
    .angle_o     (angle),
    .rate_o      (rate),
    .speed_o     (speed),
    .time_o      (sample_time_o),
    .valid_res_o (valid_res_o)
  );

  assign empty         = !out_valid;
  assign left_count_o  = count[0];
  assign right_count_o = count[1];
  assign left_angle_o  = angle[0];
  assign right_angle_o = angle[1];
  assign left_rate_o   = rate[0];
  assign right_rate_o  = rate[1];
  assign left_speed_o  = speed[0];
  assign right_speed_o = speed[1];

endmodule

/* src/qdv_front.sv */
// Front end: pin decoding, start handling and read request capture.
module qdv_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [1:0]         mode_i,
  input  logic               wheel_i,
  input  logic [1:0]         left_pins_i,
  input  logic [1:0]         right_pins_i,
  input  logic [31:0]        now_us_i,
  input  logic [31:0]        idle_timeout_i,
  input  logic               req_full_i,
  output logic               req_push_o,
  output qdv_pkg::req_t      req_o
);
  import qdv_pkg::*;

  logic                 started_q;
  logic [1:0][1:0]      prev_q;
  logic [1:0][CntW-1:0] total_q;
  logic [1:0][CntW-1:0] at_q;
  logic [1:0][31:0]     edge_q;
  logic [31:0]          last_q;
  logic                 accept;
  logic [1:0]           cur_pins;
  step_e                step;
  logic [31:0]          dt;
  logic [1:0][31:0]     idle;

  assign accept   = push_i && !req_full_i;
  assign cur_pins = wheel_i ? right_pins_i : left_pins_i;
  assign step     = step_decode(prev_q[wheel_i], cur_pins);
  assign dt       = now_us_i - last_q;
  assign idle[0]  = now_us_i - edge_q[0];
  assign idle[1]  = now_us_i - edge_q[1];

  assign req_push_o      = accept && (mode_i == ModeRead);
  assign req_o.started   = started_q;
  assign req_o.total     = total_q;
  assign req_o.at_read   = at_q;
  assign req_o.run[0]    = (dt != 32'd0) && (idle[0] <= idle_timeout_i);
  assign req_o.run[1]    = (dt != 32'd0) && (idle[1] <= idle_timeout_i);
  assign req_o.dt        = dt;
  assign req_o.now       = now_us_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      prev_q    <= '0;
      total_q   <= '0;
      at_q      <= '0;
      edge_q    <= '0;
      last_q    <= '0;
    end else if (accept) begin
      case (mode_i)
        ModePin: begin
          if (started_q) begin
            prev_q[wheel_i] <= cur_pins;
            if (step != StepNone) begin
              total_q[wheel_i] <= (step == StepUp) ? total_q[wheel_i] + CntW'(1)
                                                   : total_q[wheel_i] - CntW'(1);
              edge_q[wheel_i]  <= now_us_i;
            end
          end
        end
        ModeStart: begin
          started_q <= 1'b1;
          prev_q[0] <= left_pins_i;
          prev_q[1] <= right_pins_i;
          total_q   <= '0;
          at_q      <= '0;
          edge_q[0] <= now_us_i;
          edge_q[1] <= now_us_i;
          last_q    <= now_us_i;
        end
        ModeRead: begin
          if (started_q) begin
            last_q <= now_us_i;
            at_q   <= total_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* src/qdv_fifo.sv */
// Short request queue between front and back end.
module qdv_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  qdv_pkg::req_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          avail_o,
  output qdv_pkg::req_t data_o
);
  import qdv_pkg::*;

  localparam int PtrW = (ReqDepth > 1) ? $clog2(ReqDepth) : 1;
  localparam int CntBits = $clog2(ReqDepth + 1);

  req_t               mem_q [ReqDepth];
  logic [PtrW-1:0]    wr_q, rd_q;
  logic [CntBits-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CntBits'(ReqDepth));
  assign avail_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && avail_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(ReqDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(ReqDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntBits'(do_push) - CntBits'(do_pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntBits'(ReqDepth)) else $error("queue count overflow");
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !pop_i) |=> full_o) else $error("full dropped without pop");
  a_empty_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!avail_o && !push_i) |=> !avail_o) else $error("entry appeared without push");

endmodule

/* src/qdv_back.sv */
// Back end: angle, rate and speed arithmetic with a shared multiplier and serial divider.
module qdv_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_avail_i,
  input  qdv_pkg::req_t         req_i,
  output logic                  req_pop_o,
  input  logic [23:0]           rpc_i,
  input  logic [15:0]           radius_i,
  output logic                  out_valid_o,
  input  logic                  out_pop_i,
  output logic [1:0][31:0]      count_o,
  output logic [1:0][31:0]      angle_o,
  output logic [1:0][31:0]      rate_o,
  output logic [1:0][31:0]      speed_o,
  output logic [31:0]           time_o,
  output logic                  valid_res_o
);
  import qdv_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StMulAng, StAng, StMulDlt, StMulLo, StMulHi, StDiv, StRnd, StSpd, StOut
  } state_e;

  state_e           state_q;
  req_t             r_q;
  logic             w_q;
  logic [55:0]      p_q;
  logic [75:0]      n_q;
  logic [40:0]      rem_q;
  logic [31:0]      quo_q;
  logic             ovf_q;
  logic [6:0]       cnt_q;
  logic [31:0]      rmag_q;
  logic [1:0][31:0] count_q, angle_q, rate_q, speed_q;
  logic [31:0]      time_q;
  logic             valid_q;

  logic [CntW-1:0]  tot, dlt, mag, dmag;
  logic             neg, dneg;
  logic [31:0]      mul_a;
  logic [23:0]      mul_b;
  logic [55:0]      prod;
  logic [39:0]      divisor;
  logic [40:0]      sh;
  logic             ge;
  logic [32:0]      ang33, rate33;
  logic [39:0]      spd_sum;

  assign tot     = r_q.total[w_q];
  assign dlt     = r_q.total[w_q] - r_q.at_read[w_q];
  assign neg     = tot[CntW-1];
  assign dneg    = dlt[CntW-1];
  assign mag     = neg ? CntW'(0) - tot : tot;
  assign dmag    = dneg ? CntW'(0) - dlt : dlt;
  assign divisor = {r_q.dt, 8'd0};
  assign sh      = {rem_q[39:0], n_q[75]};
  assign ge      = sh >= {1'b0, divisor};
  assign ang33   = (p_q[55:40] != '0) ? 33'h100000000
                                      : {1'b0, p_q[39:8]} + 33'(p_q[7]);
  assign rate33  = ovf_q ? 33'h100000000
                         : {1'b0, quo_q} + 33'({rem_q, 1'b0} >= {2'b0, divisor});
  assign spd_sum = prod[55:16] + 40'(prod[15]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StMulAng: begin
        mul_a = 32'(mag);
        mul_b = rpc_i;
      end
      StMulDlt: begin
        mul_a = 32'(dmag);
        mul_b = rpc_i;
      end
      StMulLo: begin
        mul_a = {4'd0, p_q[27:0]};
        mul_b = UsPerSec;
      end
      StMulHi: begin
        mul_a = {4'd0, p_q[55:28]};
        mul_b = UsPerSec;
      end
      StSpd: begin
        mul_a = rmag_q;
        mul_b = {8'd0, radius_i};
      end
      default: begin
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign req_pop_o   = (state_q == StIdle) && req_avail_i;
  assign out_valid_o = valid_q;
  assign count_o     = count_q;
  assign angle_o     = angle_q;
  assign rate_o      = rate_q;
  assign speed_o     = speed_q;
  assign time_o      = time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= 1'b0;
      w_q         <= 1'b0;
      cnt_q       <= '0;
      valid_res_o <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (req_avail_i) begin
            r_q <= req_i;
            w_q <= 1'b0;
            if (req_i.started) begin
              count_q[0]  <= 32'(signed'(req_i.total[0]));
              count_q[1]  <= 32'(signed'(req_i.total[1]));
              time_q      <= req_i.now;
              valid_res_o <= 1'b1;
              state_q     <= StMulAng;
            end else begin
              count_q     <= '0;
              angle_q     <= '0;
              rate_q      <= '0;
              speed_q     <= '0;
              time_q      <= '0;
              valid_res_o <= 1'b0;
              valid_q     <= 1'b1;
              state_q     <= StOut;
            end
          end
        end
        StMulAng: begin
          p_q     <= prod;
          state_q <= StAng;
        end
        StAng: begin
          angle_q[w_q] <= sat_bits(neg, ang33);
          state_q      <= StMulDlt;
        end
        StMulDlt: begin
          p_q <= prod;
          if (r_q.run[w_q]) begin
            state_q <= StMulLo;
          end else begin
            rmag_q  <= '0;
            state_q <= StSpd;
          end
        end
        StMulLo: begin
          n_q     <= {20'd0, prod};
          state_q <= StMulHi;
        end
        StMulHi: begin
          n_q     <= n_q + {prod[47:0], 28'd0};
          rem_q   <= '0;
          quo_q   <= '0;
          ovf_q   <= 1'b0;
          cnt_q   <= 7'd75;
          state_q <= StDiv;
        end
        StDiv: begin
          rem_q <= ge ? sh - {1'b0, divisor} : sh;
          quo_q <= {quo_q[30:0], ge};
          ovf_q <= ovf_q | quo_q[31];
          n_q   <= {n_q[74:0], 1'b0};
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == '0) begin
            state_q <= StRnd;
          end
        end
        StRnd: begin
          rmag_q  <= 32'(clamp_mag(dneg, rate33));
          state_q <= StSpd;
        end
        StSpd: begin
          rate_q[w_q]  <= sat_bits(dneg, {1'b0, rmag_q});
          speed_q[w_q] <= sat_bits(dneg, {1'b0, spd_sum[31:0]});
          if (w_q) begin
            valid_q <= 1'b1;
            state_q <= StOut;
          end else begin
            w_q     <= 1'b1;
            state_q <= StMulAng;
          end
        end
        StOut: begin
          if (out_pop_i) begin
            valid_q <= 1'b0;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  a_valid_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q == (state_q == StOut)) else $error("result valid out of step with state");
  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && cnt_q == '0) |=> state_q == StRnd) else $error("divider overrun");
  a_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_pop_o |=> state_q != StIdle) else $error("request taken without work");

endmodule

/* sim/quadrature_decoder_velocity_tb.sv */
// Testbench for the quadrature decoder: directed and random requests against a local predictor.
module quadrature_decoder_velocity_tb;
  import qdv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ModeNop = 2'd3;

  typedef struct {
    logic [31:0] cnt[2];
    logic [31:0] ang[2];
    logic [31:0] rate[2];
    logic [31:0] spd[2];
    logic [31:0] stime;
    logic        vld;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [1:0] mode_i = ModePin;
  logic wheel_i = 1'b0;
  logic [1:0] left_pins_i = '0;
  logic [1:0] right_pins_i = '0;
  logic [31:0] now_us_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [31:0] left_count_o, right_count_o, left_angle_o, right_angle_o;
  logic [31:0] left_rate_o, right_rate_o, left_speed_o, right_speed_o, sample_time_o;
  logic valid_res_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = CfgRpc;
  logic [31:0] cfg_data_i = '0;

  quadrature_decoder_velocity dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [23:0] rpc;
  logic [15:0] radius;
  logic [31:0] timeout;
  logic        armed;
  logic [1:0]  prev_pins[2];
  logic [31:0] total[2], edge_at[2], total_at_read[2];
  logic [31:0] last_read;

  reading_t readings_q[$];
  int errors = 0;
  int hold_cycles = 0;
  int pop_gap = 0;
  bit no_idle = 0;
  logic [31:0] clock_us = '0;
  logic [1:0] pins_now[2];

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [32:0] rounded_quot(logic [63:0] mag, logic [63:0] mul,
                                               logic [63:0] div);
    logic [127:0] p, q, r;
    p = {64'd0, mag} * {64'd0, mul};
    q = p / {64'd0, div};
    r = p % {64'd0, div};
    if (q >= 128'h1_0000_0000) return 33'h1_0000_0000;
    if ((r << 1) >= {64'd0, div}) q++;
    return q[32:0];
  endfunction

  function automatic logic [32:0] limit_mag(logic neg, logic [32:0] mag);
    logic [32:0] lim;
    lim = neg ? 33'h0_8000_0000 : 33'h0_7fff_ffff;
    return (mag > lim) ? lim : mag;
  endfunction

  function automatic logic [31:0] signed_bits(logic neg, logic [32:0] mag);
    logic [32:0] m;
    m = limit_mag(neg, mag);
    return neg ? 32'(33'd0 - m) : m[31:0];
  endfunction

  function automatic logic [1:0] step_fwd(logic [1:0] p);
    case (p)
      2'd0: return 2'd1;
      2'd1: return 2'd3;
      2'd3: return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] step_rev(logic [1:0] p);
    case (p)
      2'd1: return 2'd0;
      2'd3: return 2'd1;
      2'd2: return 2'd3;
      default: return 2'd2;
    endcase
  endfunction

  function automatic void predict_reset();
    rpc = RpcReset;
    radius = RadiusReset;
    timeout = TimeoutReset;
    armed = 1'b0;
    for (int w = 0; w < 2; w++) begin
      prev_pins[w] = '0;
      total[w] = '0;
      edge_at[w] = '0;
      total_at_read[w] = '0;
    end
    last_read = '0;
  endfunction

  function automatic void predict_request(logic [1:0] md, logic wh, logic [1:0] lp,
                                          logic [1:0] rp, logic [31:0] now);
    reading_t rd;
    logic [1:0] cur;
    logic neg, dneg;
    logic [31:0] delta, dt, idle;
    logic [32:0] mag, dmag, rate, spd;
    logic [63:0] prod;
    if (md == ModePin) begin
      if (!armed) return;
      cur = wh ? rp : lp;
      if (cur == step_fwd(prev_pins[wh])) begin
        total[wh] = total[wh] + 32'd1;
        edge_at[wh] = now;
      end else if (cur == step_rev(prev_pins[wh])) begin
        total[wh] = total[wh] - 32'd1;
        edge_at[wh] = now;
      end
      prev_pins[wh] = cur;
    end else if (md == ModeStart) begin
      armed = 1'b1;
      prev_pins[0] = lp;
      prev_pins[1] = rp;
      for (int w = 0; w < 2; w++) begin
        total[w] = '0;
        total_at_read[w] = '0;
        edge_at[w] = now;
      end
      last_read = now;
    end else if (md == ModeRead) begin
      for (int w = 0; w < 2; w++) begin
        rd.cnt[w] = '0;
        rd.ang[w] = '0;
        rd.rate[w] = '0;
        rd.spd[w] = '0;
      end
      rd.stime = '0;
      rd.vld = 1'b0;
      if (armed) begin
        dt = now - last_read;
        for (int w = 0; w < 2; w++) begin
          neg = total[w][31];
          mag = neg ? 33'h1_0000_0000 - {1'b0, total[w]} : {1'b0, total[w]};
          delta = total[w] - total_at_read[w];
          dneg = delta[31];
          dmag = dneg ? 33'h1_0000_0000 - {1'b0, delta} : {1'b0, delta};
          idle = now - edge_at[w];
          rd.cnt[w] = total[w];
          rd.ang[w] = signed_bits(neg, rounded_quot(64'(mag), 64'(rpc), 64'd256));
          rate = '0;
          spd = '0;
          if (dt != 0 && idle <= timeout) begin
            rate = limit_mag(dneg, rounded_quot(64'(dmag), 64'(rpc) * 64'd1000000,
                                                {24'd0, dt, 8'd0}));
            prod = 64'(rate) * 64'(radius) + 64'd32768;
            spd = 33'(prod >> 16);
          end
          rd.rate[w] = signed_bits(dneg, rate);
          rd.spd[w] = signed_bits(dneg, spd);
          total_at_read[w] = total[w];
        end
        rd.stime = now;
        rd.vld = 1'b1;
        last_read = now;
      end
      readings_q.push_back(rd);
    end
  endfunction

  task automatic send(logic [1:0] md, logic wh, logic [1:0] lp, logic [1:0] rp,
                      logic [31:0] now);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    push <= 1'b1;
    mode_i <= md;
    wheel_i <= wh;
    left_pins_i <= lp;
    right_pins_i <= rp;
    now_us_i <= now;
    do @(posedge clk_i); while (full);
    predict_request(md, wh, lp, rp, now);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (readings_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgRpc: rpc = data[23:0];
      CfgRadius: radius = data[15:0];
      default: timeout = data;
    endcase
  endtask

  task automatic configure(logic [23:0] r, logic [15:0] rad, logic [31:0] t);
    drain();
    write_reg(CfgRpc, {8'd0, r});
    write_reg(CfgRadius, {16'd0, rad});
    write_reg(CfgTimeout, t);
  endtask

  task automatic pin_step(logic wh, int dir);
    logic [1:0] nxt;
    nxt = (dir > 0) ? step_fwd(pins_now[wh]) : (dir < 0) ? step_rev(pins_now[wh]) :
          2'($urandom);
    pins_now[wh] = nxt;
    clock_us += $urandom_range(0, 40);
    send(ModePin, wh, wh ? 2'($urandom) : nxt, wh ? nxt : 2'($urandom), clock_us);
  endtask

  task automatic start_wheels(logic [31:0] now);
    pins_now[0] = 2'($urandom);
    pins_now[1] = 2'($urandom);
    clock_us = now;
    send(ModeStart, 1'($urandom), pins_now[0], pins_now[1], now);
  endtask

  task automatic random_requests(int n, int read_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < read_pct) begin
        case ($urandom_range(0, 9))
          0: ;
          1: clock_us += $urandom_range(100000, 300000);
          2: clock_us = $urandom;
          default: clock_us += $urandom_range(1, 3000);
        endcase
        send(ModeRead, 1'($urandom), 2'($urandom), 2'($urandom), clock_us);
      end else if (r < read_pct + 2) begin
        start_wheels($urandom);
      end else if (r < read_pct + 4) begin
        send(ModeNop, 1'($urandom), 2'($urandom), 2'($urandom), $urandom);
      end else begin
        r = $urandom_range(0, 9);
        pin_step(1'($urandom), (r < 5) ? 1 : (r < 9) ? -1 : 0);
      end
    end
  endtask

  task automatic test_before_start();
    send(ModeRead, 1'b1, 2'd3, 2'd3, 32'hffff_ffff);
    send(ModePin, 1'b0, 2'd1, 2'd2, 32'd5);
    send(ModeNop, 1'b1, 2'd3, 2'd3, 32'd7);
    send(ModeRead, 1'b0, 2'd0, 2'd0, 32'd0);
  endtask

  task automatic test_directed();
    start_wheels(32'hffff_fff0);
    for (int i = 0; i < 4; i++) pin_step(1'b0, 1);
    for (int i = 0; i < 3; i++) pin_step(1'b1, -1);
    pins_now[0] = step_fwd(step_fwd(pins_now[0]));
    send(ModePin, 1'b0, pins_now[0], 2'd0, clock_us);
    send(ModePin, 1'b1, 2'd3, pins_now[1], clock_us);
    clock_us += 32'd100;
    send(ModeRead, 1'b0, 2'd0, 2'd0, clock_us);
    send(ModeRead, 1'b0, 2'd0, 2'd0, clock_us);
    pin_step(1'b1, -1);
    send(ModeRead, 1'b1, 2'd3, 2'd3, clock_us + 32'd1);
    clock_us += 32'd500000;
    send(ModeRead, 1'b1, 2'd0, 2'd0, clock_us);
    start_wheels(32'd0);
    pin_step(1'b0, -1);
    send(ModeRead, 1'b0, 2'd0, 2'd0, 32'd1);
  endtask

  task automatic test_config();
    configure(24'hff_ffff, 16'hffff, 32'd0);
    start_wheels($urandom);
    random_requests(120, 20);
    configure(24'd1, 16'd1, 32'hffff_ffff);
    random_requests(100, 20);
    configure(24'($urandom), 16'($urandom), $urandom_range(0, 5000));
    random_requests(100, 20);
    configure(RpcReset, RadiusReset, TimeoutReset);
    random_requests(120, 15);
  endtask

  task automatic test_backpressure();
    hold_cycles = 800;
    random_requests(80, 40);
    drain();
    random_requests(100, 15);
  endtask

  task automatic test_no_idle();
    drain();
    no_idle = 1;
    random_requests(150, 15);
  endtask

  always @(posedge clk_i) begin
    reading_t want;
    logic [31:0] got_cnt[2], got_ang[2], got_rate[2], got_spd[2];
    if (pop && !empty) begin
      got_cnt = '{left_count_o, right_count_o};
      got_ang = '{left_angle_o, right_angle_o};
      got_rate = '{left_rate_o, right_rate_o};
      got_spd = '{left_speed_o, right_speed_o};
      if (readings_q.size() == 0) begin
        report("unexpected result", sample_time_o, '0);
      end else begin
        want = readings_q.pop_front();
        for (int w = 0; w < 2; w++) begin
          if (got_cnt[w] !== want.cnt[w])
            report($sformatf("count%0d", w), got_cnt[w], want.cnt[w]);
          if (got_ang[w] !== want.ang[w])
            report($sformatf("angle%0d", w), got_ang[w], want.ang[w]);
          if (got_rate[w] !== want.rate[w])
            report($sformatf("rate%0d", w), got_rate[w], want.rate[w]);
          if (got_spd[w] !== want.spd[w])
            report($sformatf("speed%0d", w), got_spd[w], want.spd[w]);
        end
        if (sample_time_o !== want.stime) report("sample_time", sample_time_o, want.stime);
        if (valid_res_o !== want.vld) report("valid_res", 32'(valid_res_o), 32'(want.vld));
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else if (no_idle) begin
      pop <= 1'b1;
    end else if (pop_gap > 0) begin
      pop_gap <= pop_gap - 1;
      pop <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      pop_gap <= $urandom_range(0, 3);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    #16ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    predict_reset();
    pins_now = '{2'd0, 2'd0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_before_start();
    test_directed();
    test_config();
    test_backpressure();
    test_no_idle();
    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
